>>> rtl/kft_pkg.sv
// Shared types and codes for the keyframe track sampler.
package kft_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FIXED = 2'd0,
        KIND_INT   = 2'd1,
        KIND_BOOL  = 2'd2,
        KIND_COLOR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2,
        STAT_RSVD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_UPDATE = 2'd2,
        CH_DELETE = 2'd3
    } chain_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDIT,
        ST_PICK,
        ST_SETUP,
        ST_MULA,
        ST_MULB,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_LEN  = 1'b1;

    localparam int NUM_W = 55;
    localparam int DIV_W = 18;

endpackage

>>> rtl/kft_cell.sv
// One key slot of the sorted key chain: holds a position and a value.
module kft_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  kft_pkg::chain_op_t op,
    input  logic [15:0]       frame,
    input  logic [31:0]       value,
    input  logic [CW-1:0]     count,
    input  logic [15:0]       prev_pos,
    input  logic [31:0]       prev_val,
    input  logic              prev_lt,
    input  logic [15:0]       next_pos,
    input  logic [31:0]       next_val,
    output logic [15:0]       pos,
    output logic [31:0]       val,
    output logic              valid,
    output logic              lt,
    output logic              le,
    output logic              eq
);

    logic [15:0] pos_reg;
    logic [31:0] val_reg;

    // compare own key against the item frame
    assign valid = count > CW'(IDX);
    assign lt    = valid && (pos_reg < frame);
    assign le    = valid && (pos_reg <= frame);
    assign eq    = valid && (pos_reg == frame);
    assign pos   = pos_reg;
    assign val   = val_reg;

    // shift, insert or overwrite
    always_ff @(posedge clk)
    begin
        unique case (op)
            kft_pkg::CH_INSERT:
            begin
                if (!lt)
                begin
                    if (prev_lt)
                    begin
                        pos_reg <= frame;
                        val_reg <= value;
                    end
                    else
                    begin
                        pos_reg <= prev_pos;
                        val_reg <= prev_val;
                    end
                end
            end
            kft_pkg::CH_DELETE:
            begin
                if (!lt)
                begin
                    pos_reg <= next_pos;
                    val_reg <= next_val;
                end
            end
            kft_pkg::CH_UPDATE:
            begin
                if (eq)
                begin
                    val_reg <= value;
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

endmodule

>>> rtl/kft_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module kft_div #(
    parameter int NW = 55,
    parameter int DW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     rem_sh;
    logic            fits;

    // trial subtract of the shifted remainder
    assign rem_sh   = {rem_reg, quo_reg[NW-1]};
    assign fits     = rem_sh >= {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(rem_sh - {1'b0, dvs_reg}) : DW'(rem_sh);
        end
    end

endmodule

>>> rtl/keyframe_track_sampler.sv
// Top level of the keyframe track sampler: key chain, sequencer and lerp datapath.
//
// Usage: items enter on the item channel (mode, frame_pos, key_value, loop_on) and are
// taken when item_valid is high and item_stall low. Each item gives one result beat
// (sample_out, status, key_count) on the result channel, taken when result_valid is
// high and result_stall low. Registers value_kind (index 0) and anim_length (index 1)
// are written through cfg_valid/cfg_ready, always ready; write them only when idle.
// Keys live in a chain of MAX_KEYS cells sorted by position; an add or remove shifts
// the whole chain in the edit state, and an update overwrites the matching cell's value.
// A sample picks its bracketing keys from the chain in the pick state, then runs two
// multiplies, a sum and a 55-bit restoring divide at one bit per cycle for Q16.16 and
// integer kinds, and up to one divide per channel for color; boolean, empty or single-key
// tracks skip the multiplies and the divide.
// One item is worked at a time; a new item is taken as soon as the previous result
// sits in the output register, which holds while result_stall is high.
// Reset empties the track, sets value_kind to Q16.16 and anim_length to 60.
module keyframe_track_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] frame_pos,
    input  logic [31:0] key_value,
    input  logic        loop_on,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] sample_out,
    output logic [1:0]  status,
    output logic [6:0]  key_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int NW = kft_pkg::NUM_W;
    localparam int DW = kft_pkg::DIV_W;

    kft_pkg::state_t    state_reg, state_next;
    kft_pkg::chain_op_t chain_op;

    logic [1:0]  kind_reg;
    logic [15:0] len_reg;
    logic [CW-1:0] count_reg, count_next;

    logic [1:0]  mode_reg;
    logic [15:0] f_reg;
    logic [31:0] val_reg;
    logic        loop_reg;

    logic [15:0] lp_reg, lp_next, rp_reg, rp_next;
    logic [31:0] sv_reg, sv_next, ev_reg, ev_next;
    logic signed [17:0] delta_reg, delta_next;
    logic signed [18:0] cur_reg, cur_next;
    logic signed [51:0] pa_reg;
    logic signed [53:0] pb_reg;
    logic signed [NW-1:0] num_reg;
    logic [1:0]  chan_reg, chan_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  stat_reg, stat_next;

    logic        rv_reg;
    logic [31:0] out_res_reg;
    logic [1:0]  out_stat_reg;
    logic [6:0]  out_cnt_reg;

    // chain wires
    logic [15:0] pos_w [MAX_KEYS];
    logic [31:0] kval_w [MAX_KEYS];
    logic        valid_w [MAX_KEYS];
    logic        lt_w [MAX_KEYS];
    logic        le_w [MAX_KEYS];
    logic        eq_w [MAX_KEYS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++)
        begin : g_cell
            logic [15:0] pp, np;
            logic [31:0] pv, nv;
            logic        plt;
            if (gi == 0)
            begin : g_first
                assign pp  = 16'd0;
                assign pv  = 32'd0;
                assign plt = 1'b1;
            end
            else
            begin : g_mid
                assign pp  = pos_w[gi-1];
                assign pv  = kval_w[gi-1];
                assign plt = lt_w[gi-1];
            end
            if (gi == MAX_KEYS - 1)
            begin : g_last
                assign np = pos_w[gi];
                assign nv = kval_w[gi];
            end
            else
            begin : g_inner
                assign np = pos_w[gi+1];
                assign nv = kval_w[gi+1];
            end
            kft_cell #(.IDX(gi), .CW(CW)) u_cell (
                .clk      (clk),
                .op       (chain_op),
                .frame    (f_reg),
                .value    (val_reg),
                .count    (count_reg),
                .prev_pos (pp),
                .prev_val (pv),
                .prev_lt  (plt),
                .next_pos (np),
                .next_val (nv),
                .pos      (pos_w[gi]),
                .val      (kval_w[gi]),
                .valid    (valid_w[gi]),
                .lt       (lt_w[gi]),
                .le       (le_w[gi]),
                .eq       (eq_w[gi])
            );
        end
    endgenerate

    // find match and the bracketing cells
    logic        match;
    logic [15:0] l_pos, r_pos, last_pos;
    logic [31:0] l_val, r_val, last_val;
    logic        last_le;
    always_comb
    begin
        logic nxt_le, prv_le, nxt_valid;
        match    = 1'b0;
        l_pos    = '0;
        r_pos    = '0;
        last_pos = '0;
        l_val    = '0;
        r_val    = '0;
        last_val = '0;
        last_le  = 1'b0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            nxt_le    = (i < MAX_KEYS - 1) ? le_w[(i + 1) % MAX_KEYS] : 1'b0;
            nxt_valid = (i < MAX_KEYS - 1) ? valid_w[(i + 1) % MAX_KEYS] : 1'b0;
            prv_le    = (i > 0) ? le_w[(i + MAX_KEYS - 1) % MAX_KEYS] : 1'b0;
            match = match | eq_w[i];
            if (le_w[i] && !nxt_le)
            begin
                l_pos = l_pos | pos_w[i];
                l_val = l_val | kval_w[i];
            end
            if (prv_le && !le_w[i] && valid_w[i])
            begin
                r_pos = r_pos | pos_w[i];
                r_val = r_val | kval_w[i];
            end
            if (valid_w[i] && !nxt_valid)
            begin
                last_pos = last_pos | pos_w[i];
                last_val = last_val | kval_w[i];
                last_le  = last_le | le_w[i];
            end
        end
    end

    logic full;
    assign full = count_reg == CW'(MAX_KEYS);

    // lerp operands for the current channel or word
    logic        color;
    logic [7:0]  sv_byte, ev_byte;
    logic signed [33:0] s_op, e_op;
    logic signed [34:0] diff;
    logic signed [51:0] prod_a;
    logic signed [53:0] prod_b;
    logic signed [NW-1:0] delta_ext, lim, num_sum;
    assign color     = kind_reg == kft_pkg::KIND_COLOR;
    assign sv_byte   = sv_reg[chan_reg*8 +: 8];
    assign ev_byte   = ev_reg[chan_reg*8 +: 8];
    assign s_op      = color ? {26'd0, sv_byte} : {{2{sv_reg[31]}}, sv_reg};
    assign e_op      = color ? {26'd0, ev_byte} : {{2{ev_reg[31]}}, ev_reg};
    assign diff      = e_op - s_op;
    assign prod_a    = s_op * delta_reg;
    assign prod_b    = diff * cur_reg;
    assign num_sum   = NW'(pa_reg) + NW'(pb_reg);
    assign delta_ext = NW'(delta_reg);
    assign lim       = (delta_ext <<< 8) - delta_ext;

    // divider hookup
    logic          div_start, div_done;
    logic [NW-1:0] div_a, div_q;
    logic [DW-1:0] div_b;
    assign div_a = color ? NW'((num_reg <<< 1) + delta_ext)
                         : (num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg));
    assign div_b = color ? {delta_reg[16:0], 1'b0} : {1'b0, delta_reg[16:0]};

    kft_div #(.NW(NW), .DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    // saturate the signed word quotient
    logic [31:0] word_res;
    always_comb
    begin
        if (num_reg[NW-1])
        begin
            word_res = (div_q > NW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-div_q);
        end
        else
        begin
            word_res = (div_q > NW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end
    end

    logic f_lo, f_hi, out_rng;
    assign f_lo    = f_reg < lp_reg;
    assign f_hi    = f_reg > rp_reg;
    assign out_rng = f_lo || f_hi;

    logic load_out;
    assign load_out = (state_reg == kft_pkg::ST_DONE) && (!rv_reg || !result_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kft_pkg::ST_IDLE:
                if (item_valid) state_next = kft_pkg::ST_EDIT;
            kft_pkg::ST_EDIT:
                state_next = (mode_reg == kft_pkg::MODE_SAMPLE) ? kft_pkg::ST_PICK
                                                                : kft_pkg::ST_DONE;
            kft_pkg::ST_PICK:
                state_next = (count_reg < CW'(2) || kind_reg == kft_pkg::KIND_BOOL)
                             ? kft_pkg::ST_DONE : kft_pkg::ST_SETUP;
            kft_pkg::ST_SETUP:
            begin
                if (out_rng && !loop_reg)
                    state_next = kft_pkg::ST_DONE;
                else if ((out_rng ? ($signed({2'b0, len_reg})
                                     - $signed({2'b0, rp_reg - lp_reg}))
                                  : $signed({2'b0, rp_reg - lp_reg})) <= 18'sd0)
                    state_next = kft_pkg::ST_DONE;
                else
                    state_next = kft_pkg::ST_MULA;
            end
            kft_pkg::ST_MULA: state_next = kft_pkg::ST_MULB;
            kft_pkg::ST_MULB: state_next = kft_pkg::ST_SUM;
            kft_pkg::ST_SUM:  state_next = kft_pkg::ST_CHK;
            kft_pkg::ST_CHK:
            begin
                if (color && (num_reg <= 0 || num_reg >= lim))
                    state_next = (chan_reg == 2'd3) ? kft_pkg::ST_DONE : kft_pkg::ST_MULA;
                else
                    state_next = kft_pkg::ST_DIV;
            end
            kft_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = (!color || chan_reg == 2'd3) ? kft_pkg::ST_DONE
                                                              : kft_pkg::ST_MULA;
            end
            kft_pkg::ST_DONE:
                if (load_out) state_next = kft_pkg::ST_IDLE;
            default: state_next = kft_pkg::ST_IDLE;
        endcase
    end

    // datapath and chain control
    always_comb
    begin
        chain_op   = kft_pkg::CH_HOLD;
        count_next = count_reg;
        lp_next    = lp_reg;
        rp_next    = rp_reg;
        sv_next    = sv_reg;
        ev_next    = ev_reg;
        delta_next = delta_reg;
        cur_next   = cur_reg;
        chan_next  = chan_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            kft_pkg::ST_EDIT:
            begin
                res_next  = '0;
                stat_next = kft_pkg::STAT_OK;
                priority if (mode_reg == kft_pkg::MODE_ADD)
                begin
                    if (match)
                        chain_op = kft_pkg::CH_UPDATE;
                    else if (full)
                        stat_next = kft_pkg::STAT_FULL;
                    else
                    begin
                        chain_op   = kft_pkg::CH_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (mode_reg == kft_pkg::MODE_REMOVE)
                begin
                    if (match)
                    begin
                        chain_op   = kft_pkg::CH_DELETE;
                        count_next = count_reg - 1'b1;
                    end
                    else
                        stat_next = kft_pkg::STAT_MISS;
                end
                else
                begin
                    chain_op = kft_pkg::CH_HOLD;
                end
            end
            kft_pkg::ST_PICK:
            begin
                chan_next = 2'd0;
                if (count_reg == '0)
                    res_next = '0;
                else if (count_reg == CW'(1))
                    res_next = (kind_reg == kft_pkg::KIND_BOOL) ? 32'(kval_w[0] != 0)
                                                                : kval_w[0];
                else if (kind_reg == kft_pkg::KIND_BOOL)
                begin
                    if (!le_w[0])
                        res_next = 32'((loop_reg ? last_val : kval_w[0]) != 0);
                    else
                        res_next = 32'(l_val != 0);
                end
                else if (!le_w[0] || last_le)
                begin
                    lp_next = pos_w[0];
                    rp_next = last_pos;
                    sv_next = kval_w[0];
                    ev_next = last_val;
                end
                else
                begin
                    lp_next = l_pos;
                    rp_next = r_pos;
                    sv_next = l_val;
                    ev_next = r_val;
                end
            end
            kft_pkg::ST_SETUP:
            begin
                res_next = '0;
                if (out_rng)
                begin
                    if (!loop_reg)
                        res_next = f_lo ? sv_reg : ev_reg;
                    else
                    begin
                        delta_next = $signed({2'b0, len_reg})
                                     - $signed({2'b0, rp_reg - lp_reg});
                        cur_next   = f_lo ? $signed({3'b0, f_reg}) + $signed({3'b0, len_reg})
                                            - $signed({3'b0, rp_reg})
                                          : $signed({3'b0, f_reg}) - $signed({3'b0, rp_reg});
                        sv_next    = ev_reg;
                        ev_next    = sv_reg;
                        res_next   = ev_reg;
                    end
                end
                else
                begin
                    delta_next = $signed({2'b0, rp_reg - lp_reg});
                    cur_next   = $signed({3'b0, f_reg - lp_reg});
                    res_next   = sv_reg;
                end
                if (state_next == kft_pkg::ST_MULA)
                    res_next = '0;
            end
            kft_pkg::ST_CHK:
            begin
                if (color && (num_reg <= 0 || num_reg >= lim))
                begin
                    res_next[chan_reg*8 +: 8] = (num_reg <= 0) ? 8'd0 : 8'd255;
                    chan_next = chan_reg + 1'b1;
                end
                else
                    div_start = 1'b1;
            end
            kft_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (color)
                    begin
                        res_next[chan_reg*8 +: 8] = div_q[7:0];
                        chan_next = chan_reg + 1'b1;
                    end
                    else
                        res_next = word_res;
                end
            end
            default:
            begin
                chain_op = kft_pkg::CH_HOLD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kft_pkg::ST_IDLE;
            count_reg <= '0;
            kind_reg  <= kft_pkg::KIND_FIXED;
            len_reg   <= 16'd60;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_index == kft_pkg::CFG_KIND) kind_reg <= cfg_data[1:0];
            if (cfg_valid && cfg_index == kft_pkg::CFG_LEN)  len_reg  <= cfg_data;
            if (load_out)
                rv_reg <= 1'b1;
            else if (!result_stall)
                rv_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == kft_pkg::ST_IDLE && item_valid)
        begin
            mode_reg <= mode;
            f_reg    <= frame_pos;
            val_reg  <= key_value;
            loop_reg <= loop_on;
        end
        lp_reg    <= lp_next;
        rp_reg    <= rp_next;
        sv_reg    <= sv_next;
        ev_reg    <= ev_next;
        delta_reg <= delta_next;
        cur_reg   <= cur_next;
        chan_reg  <= chan_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        if (state_reg == kft_pkg::ST_MULA) pa_reg <= prod_a;
        if (state_reg == kft_pkg::ST_MULB) pb_reg <= prod_b;
        if (state_reg == kft_pkg::ST_SUM)  num_reg <= num_sum;
        if (load_out)
        begin
            out_res_reg  <= res_reg;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= 7'({7'd0, count_reg});
        end
    end

    assign item_stall   = state_reg != kft_pkg::ST_IDLE;
    assign result_valid = rv_reg;
    assign sample_out   = out_res_reg;
    assign status       = out_stat_reg;
    assign key_count    = out_cnt_reg;
    assign cfg_ready    = 1'b1;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count above table size");

    a_accept_edit: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg == kft_pkg::ST_EDIT)
        else $error("accepted item did not enter edit");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == kft_pkg::ST_DIV)
        else $error("divider finished outside divide state");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the keyframe track sampler: queued driver, clocked monitor.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        kft_pkg::mode_t mode;
        logic [15:0]    frame;
        logic [31:0]    value;
        logic           loop;
    } track_item_t;

    typedef struct {
        logic [31:0] sample;
        logic [1:0]  status;
        logic [6:0]  count;
    } track_result_t;

    localparam int DEPTH = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  mode = 2'd0;
    logic [15:0] frame_pos = 16'd0;
    logic [31:0] key_value = 32'd0;
    logic        loop_on = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] sample_out;
    logic [1:0]  status;
    logic [6:0]  key_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'd0;

    // shadow track state
    logic [15:0]    trk_pos [DEPTH];
    logic [31:0]    trk_val [DEPTH];
    int             trk_n = 0;
    kft_pkg::kind_t trk_kind = kft_pkg::KIND_FIXED;
    int             trk_len = 60;

    track_item_t   pend_q[$];
    track_result_t want_q[$];
    track_item_t   cur_item;
    bit            quiet = 1'b0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            errors = 0;
    int            n_acc = 0, n_samp = 0, n_full = 0, n_miss = 0, n_phase = 0;

    always #1 clk = ~clk;

    keyframe_track_sampler i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .mode(mode), .frame_pos(frame_pos), .key_value(key_value), .loop_on(loop_on),
        .result_valid(result_valid), .result_stall(result_stall),
        .sample_out(sample_out), .status(status), .key_count(key_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [31:0] norm_raw(logic [31:0] v);
        if (trk_kind == kft_pkg::KIND_BOOL)
            return (v != 0) ? 32'd1 : 32'd0;
        return v;
    endfunction

    function automatic logic [31:0] lerp_word(logic [31:0] s, logic [31:0] e,
                                              longint cur, longint dl);
        longint sv, ev, q;
        sv = longint'(signed'(s));
        ev = longint'(signed'(e));
        q = (sv * dl + (ev - sv) * cur) / dl;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [31:0] lerp_color(logic [31:0] s, logic [31:0] e,
                                               longint cur, longint dl);
        logic [31:0] r;
        longint a, b, num, c;
        r = '0;
        for (int sh = 0; sh < 32; sh += 8)
        begin
            a = longint'(s[sh +: 8]);
            b = longint'(e[sh +: 8]);
            num = a * dl + (b - a) * cur;
            if (num <= 0) c = 0;
            else if (num >= 255 * dl) c = 255;
            else c = (2 * num + dl) / (2 * dl);
            r[sh +: 8] = c[7:0];
        end
        return r;
    endfunction

    // value of the track at frame f
    function automatic logic [31:0] sample_track(longint f, bit lp);
        int n, left, li, ri;
        longint lpos, rpos, cur, dl;
        logic [31:0] sv, ev;
        n = trk_n;
        if (n == 0) return 32'd0;
        if (n == 1) return norm_raw(trk_val[0]);
        if (trk_kind == kft_pkg::KIND_BOOL)
        begin
            if (f < trk_pos[0]) return norm_raw(lp ? trk_val[n-1] : trk_val[0]);
            if (f > trk_pos[n-1]) return norm_raw(trk_val[n-1]);
        end
        left = -1;
        for (int i = 0; i < n; i++)
        begin
            if (trk_pos[i] <= f) left = i;
            else break;
        end
        if (trk_kind == kft_pkg::KIND_BOOL) return norm_raw(trk_val[left < 0 ? 0 : left]);
        li = left < 0 ? 0 : left;
        ri = (li + 1) % n;
        if (ri < li)
        begin
            ri = li;
            li = 0;
        end
        if (f < trk_pos[li]) ri = n - 1;
        lpos = trk_pos[li];
        rpos = trk_pos[ri];
        sv = trk_val[li];
        ev = trk_val[ri];
        dl = rpos - lpos;
        cur = f - lpos;
        if (f < lpos || f > rpos)
        begin
            if (!lp) return (f < lpos) ? sv : ev;
            dl = trk_len - (rpos - lpos);
            cur = (f < lpos) ? f + (trk_len - rpos) : f - rpos;
            sv = trk_val[ri];
            ev = trk_val[li];
        end
        if (dl <= 0) return sv;
        if (trk_kind == kft_pkg::KIND_COLOR) return lerp_color(sv, ev, cur, dl);
        return lerp_word(sv, ev, cur, dl);
    endfunction

    function automatic int find_pos(logic [15:0] f);
        for (int i = 0; i < trk_n; i++)
            if (trk_pos[i] == f) return i;
        return -1;
    endfunction

    // apply one accepted item to the shadow track and queue its result
    function automatic void apply_item(track_item_t it);
        track_result_t r;
        int k, p;
        r.sample = '0;
        r.status = kft_pkg::STAT_OK;
        if (it.mode == kft_pkg::MODE_ADD)
        begin
            k = find_pos(it.frame);
            if (k >= 0) trk_val[k] = it.value;
            else if (trk_n >= DEPTH) r.status = kft_pkg::STAT_FULL;
            else
            begin
                p = 0;
                while (p < trk_n && trk_pos[p] < it.frame) p++;
                for (int i = trk_n; i > p; i--)
                begin
                    trk_pos[i] = trk_pos[i-1];
                    trk_val[i] = trk_val[i-1];
                end
                trk_pos[p] = it.frame;
                trk_val[p] = it.value;
                trk_n++;
            end
        end
        else if (it.mode == kft_pkg::MODE_REMOVE)
        begin
            k = find_pos(it.frame);
            if (k < 0) r.status = kft_pkg::STAT_MISS;
            else
            begin
                for (int i = k; i + 1 < trk_n; i++)
                begin
                    trk_pos[i] = trk_pos[i+1];
                    trk_val[i] = trk_val[i+1];
                end
                trk_n--;
            end
        end
        else if (it.mode == kft_pkg::MODE_SAMPLE)
        begin
            r.sample = sample_track(longint'(it.frame), it.loop);
            n_samp++;
        end
        if (r.status == kft_pkg::STAT_FULL) n_full++;
        if (r.status == kft_pkg::STAT_MISS) n_miss++;
        r.count = trk_n[6:0];
        want_q.insert(want_q.size(), r);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
        $display("mismatch %s: got %h want %h", what, got, exp_v);
        errors++;
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        bit take;
        track_item_t it;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            take = item_valid && !item_stall;
            if (take)
            begin
                apply_item(cur_item);
                n_acc++;
            end
            if (!item_valid || take)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (pend_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0)
                begin
                    gap_left <= $urandom_range(0, 7);
                    item_valid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    it = pend_q.pop_front();
                    cur_item = it;
                    mode <= it.mode;
                    frame_pos <= it.frame;
                    key_value <= it.value;
                    loop_on <= it.loop;
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin : mon
        track_result_t r;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (want_q.size() == 0)
                    report("unexpected beat", sample_out, 32'd0);
                else
                begin
                    r = want_q.pop_front();
                    if (sample_out !== r.sample) report("sample_out", sample_out, r.sample);
                    if (status !== r.status) report("status", 32'(status), 32'(r.status));
                    if (key_count !== r.count)
                        report("key_count", 32'(key_count), 32'(r.count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 7);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic cfg_write(logic idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kft_pkg::CFG_KIND) trk_kind = kft_pkg::kind_t'(data[1:0]);
        else trk_len = int'(data);
    endtask

    task automatic push(kft_pkg::mode_t m, logic [15:0] f, logic [31:0] v, logic lp);
        track_item_t it;
        it.mode = m;
        it.frame = f;
        it.value = v;
        it.loop = lp;
        pend_q.insert(pend_q.size(), it);
    endtask

    // let the bench go idle: nothing pending, nothing outstanding
    task automatic drain();
        wait (pend_q.size() == 0 && want_q.size() == 0 && !item_valid);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
            3: return 32'($urandom_range(0, 1));
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(kft_pkg::kind_t k, logic [15:0] len, int count);
        int sel;
        logic [15:0] f;
        cfg_write(kft_pkg::CFG_KIND, 16'(k));
        cfg_write(kft_pkg::CFG_LEN, len);
        n_phase++;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            f = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 120));
            if (sel < 35)
                push(kft_pkg::MODE_ADD, f, rand_value(), 1'($urandom_range(0, 1)));
            else if (sel < 52)
                push(kft_pkg::MODE_REMOVE, f, $urandom(), 1'($urandom_range(0, 1)));
            else if (sel < 96)
                push(kft_pkg::MODE_SAMPLE, f, $urandom(), 1'($urandom_range(0, 1)));
            else
                push(kft_pkg::MODE_NONE, f, $urandom(), 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty track, extremes, every mode, single key
        push(kft_pkg::MODE_SAMPLE, 16'd5, 32'h0, 1'b1);
        push(kft_pkg::MODE_REMOVE, 16'd7, 32'h0, 1'b0);
        push(kft_pkg::MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        push(kft_pkg::MODE_ADD, 16'd10, 32'h7FFF_FFFF, 1'b0);
        push(kft_pkg::MODE_SAMPLE, 16'd0, 32'h0, 1'b0);
        push(kft_pkg::MODE_ADD, 16'hFFFF, 32'h8000_0000, 1'b0);
        push(kft_pkg::MODE_ADD, 16'd0, 32'hFFFF_FFFF, 1'b0);
        push(kft_pkg::MODE_ADD, 16'd10, 32'h0001_0000, 1'b0);
        push(kft_pkg::MODE_SAMPLE, 16'd5, 32'h0, 1'b0);
        push(kft_pkg::MODE_SAMPLE, 16'd5, 32'h0, 1'b1);
        push(kft_pkg::MODE_SAMPLE, 16'hFFFF, 32'h0, 1'b1);
        push(kft_pkg::MODE_SAMPLE, 16'h8000, 32'h0, 1'b1);
        push(kft_pkg::MODE_SAMPLE, 16'd30, 32'h0, 1'b0);
        push(kft_pkg::MODE_REMOVE, 16'hFFFF, 32'h0, 1'b0);
        push(kft_pkg::MODE_SAMPLE, 16'd40, 32'h0, 1'b1);
        drain();

        // fill the table, overflow it, overwrite while full, then empty it
        for (int i = 0; i < DEPTH; i++)
            push(kft_pkg::MODE_ADD, 16'(1000 + 3 * i), $urandom(), 1'b0);
        push(kft_pkg::MODE_ADD, 16'd5, 32'h1234_5678, 1'b0);
        push(kft_pkg::MODE_ADD, 16'd1000, 32'hCAFE_0000, 1'b0);
        push(kft_pkg::MODE_SAMPLE, 16'd1001, 32'h0, 1'b0);
        drain();
        for (int i = 0; i < DEPTH + 3; i++)
            push(kft_pkg::MODE_REMOVE, 16'(i < 3 ? i : 1000 + 3 * (i - 3)), 32'h0, 1'b0);
        drain();

        // random phases over every value kind and a range of loop lengths
        random_phase(kft_pkg::KIND_FIXED, 16'd60, 56);
        random_phase(kft_pkg::KIND_INT, 16'd1, 56);
        random_phase(kft_pkg::KIND_COLOR, 16'd200, 56);
        random_phase(kft_pkg::KIND_BOOL, 16'hFFFF, 56);
        random_phase(kft_pkg::KIND_COLOR, 16'd1, 60);
        random_phase(kft_pkg::KIND_INT, 16'hFFFF, 56);
        random_phase(kft_pkg::KIND_BOOL, 16'd90, 60);
        quiet = 1'b1;
        random_phase(kft_pkg::KIND_FIXED, 16'($urandom_range(1, 400)), 56);

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d beats in %0d phases: %0d samples, %0d full adds, %0d misses",
                 n_acc, n_phase, n_samp, n_full, n_miss);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
